// ===== sv/ffc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types and constants for the float format converter.
// ----------------------------------------------------------------------------
package ffc_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned F64FracW = 52;
  localparam int unsigned F64ExpW = 11;
  localparam int unsigned F64Bias = 1023;
  localparam int unsigned LzW = 6;

  typedef enum logic [1:0] {
    FMT_F16 = 2'd0,
    FMT_F32 = 2'd1,
    FMT_F64 = 2'd2,
    FMT_RSV = 2'd3
  } fmt_t;

  localparam logic REQ_WIDEN = 1'b0;
  localparam logic REQ_NARROW = 1'b1;

  // Unpacked operand, carried from the decode stage to the normalize stage.
  typedef struct packed {
    logic                narrow;
    fmt_t                fmt;
    logic                sgn;
    logic                is_nan;
    logic                is_inf;
    logic                is_zero;
    logic                is_sub;
    logic                pass;
    logic [DataW-1:0]    raw;
    logic signed [12:0]  exp;
    logic [F64FracW-1:0] frac;
  } ffc_dec_t;

  // Normalized operand, carried from normalize to pack.
  typedef struct packed {
    logic                narrow;
    fmt_t                fmt;
    logic                sgn;
    logic                is_nan;
    logic                is_inf;
    logic                is_zero;
    logic                pass;
    logic [DataW-1:0]    raw;
    logic signed [12:0]  exp;
    logic [F64FracW-1:0] frac;
  } ffc_norm_t;

  function automatic logic [3:0] exp_width(input fmt_t f);
    case (f)
      FMT_F16: exp_width = 4'd5;
      FMT_F32: exp_width = 4'd8;
      default: exp_width = 4'd11;
    endcase
  endfunction

  function automatic logic [5:0] frac_width(input fmt_t f);
    case (f)
      FMT_F16: frac_width = 6'd10;
      FMT_F32: frac_width = 6'd23;
      default: frac_width = 6'd52;
    endcase
  endfunction

  function automatic logic [10:0] fmt_bias(input fmt_t f);
    case (f)
      FMT_F16: fmt_bias = 11'd15;
      FMT_F32: fmt_bias = 11'd127;
      default: fmt_bias = 11'd1023;
    endcase
  endfunction

endpackage

// ===== sv/ffc_decode.sv =====
// ----------------------------------------------------------------------------
// ffc_decode
// Stage one: split the operand into sign, exponent and fraction fields.
// ----------------------------------------------------------------------------
module ffc_decode (
  input  logic                    narrow,
  input  ffc_pkg::fmt_t           fmt,
  input  logic [63:0]             operand_bits,
  output ffc_pkg::ffc_dec_t       dec
);
  import ffc_pkg::*;

  logic [63:0] w16;
  logic [63:0] w32;
  logic [10:0] ex;
  logic [10:0] emask;
  logic [51:0] fr;
  logic        sg;
  fmt_t        kf;

  always_comb begin
    kf = narrow ? FMT_F64 : fmt;
    w16 = {48'd0, operand_bits[15:0]};
    w32 = {32'd0, operand_bits[31:0]};
    case (kf)
      FMT_F16: begin
        sg = w16[15];
        ex = {6'd0, w16[14:10]};
        fr = {42'd0, w16[9:0]};
        emask = 11'h1f;
      end
      FMT_F32: begin
        sg = w32[31];
        ex = {3'd0, w32[30:23]};
        fr = {29'd0, w32[22:0]};
        emask = 11'hff;
      end
      default: begin
        sg = operand_bits[63];
        ex = operand_bits[62:52];
        fr = operand_bits[51:0];
        emask = 11'h7ff;
      end
    endcase
    dec.narrow  = narrow;
    dec.fmt     = fmt;
    dec.sgn     = sg;
    dec.is_nan  = (ex == emask) && (fr != '0);
    dec.is_inf  = (ex == emask) && (fr == '0);
    dec.is_zero = (ex == '0) && (fr == '0);
    dec.is_sub  = (ex == '0) && (fr != '0);
    dec.pass    = !narrow && (fmt == FMT_F64 || fmt == FMT_RSV);
    dec.raw     = operand_bits;
    // Unbiased exponent for normal values; subnormals get fixed next stage.
    dec.exp     = $signed({2'b00, ex}) - $signed({2'b00, fmt_bias(kf)});
    dec.frac    = fr;
  end
endmodule

// ===== sv/ffc_norm.sv =====
// ----------------------------------------------------------------------------
// ffc_norm
// Stage two: normalize subnormal fractions with a leading-zero count.
// ----------------------------------------------------------------------------
module ffc_norm (
  input  ffc_pkg::ffc_dec_t  dec,
  output ffc_pkg::ffc_norm_t nrm
);
  import ffc_pkg::*;

  logic [5:0]  p;
  logic [51:0] sh;
  logic [5:0]  mw;

  always_comb begin
    mw = frac_width(dec.narrow ? FMT_F64 : dec.fmt);
    p = '0;
    for (int i = 0; i < 52; i++) begin
      if (dec.frac[i]) p = 6'(i);
    end
    sh = dec.frac << (6'd52 - p);
    nrm.narrow  = dec.narrow;
    nrm.fmt     = dec.fmt;
    nrm.sgn     = dec.sgn;
    nrm.is_nan  = dec.is_nan;
    nrm.is_inf  = dec.is_inf;
    nrm.is_zero = dec.is_zero;
    nrm.pass    = dec.pass;
    nrm.raw     = dec.raw;
    if (dec.is_sub) begin
      // value = 2^(p - mw + 1 - bias); dec.exp holds -bias already
      nrm.exp  = dec.exp + $signed({7'd0, p}) - $signed({7'd0, mw}) + 13'sd1;
      nrm.frac = sh;
    end else begin
      nrm.exp  = dec.exp;
      nrm.frac = dec.frac << (6'd52 - mw);
    end
  end
endmodule

// ===== sv/ffc_pack.sv =====
// ----------------------------------------------------------------------------
// ffc_pack
// Stage three: rebias, clamp and assemble the result pattern.
// ----------------------------------------------------------------------------
module ffc_pack (
  input  ffc_pkg::ffc_norm_t nrm,
  output logic [63:0]        result_bits
);
  import ffc_pkg::*;

  logic signed [12:0] rawe;
  logic [10:0]        emask;
  logic [51:0]        fmask;
  logic [52:0]        sig;
  logic [10:0]        ex;
  logic [51:0]        fr;
  logic [5:0]         mw;
  logic [3:0]         ew;

  always_comb begin
    mw    = frac_width(nrm.fmt);
    ew    = exp_width(nrm.fmt);
    emask = 11'((12'd1 << ew) - 12'd1);
    fmask = 52'((53'd1 << mw) - 53'd1);
    // keep the hidden bit: a narrowed result shifted into a subnormal needs it
    sig   = {1'b1, nrm.frac} >> (6'd52 - mw);
    rawe  = nrm.exp + $signed({2'b00, fmt_bias(nrm.fmt)});
    ex = '0;
    fr = '0;
    result_bits = '0;
    if (!nrm.narrow) begin
      if (nrm.is_nan) result_bits = {nrm.sgn, 63'h7FF8000000000000};
      else if (nrm.is_inf) result_bits = {nrm.sgn, 63'h7FF0000000000000};
      else if (nrm.pass) result_bits = nrm.raw;
      else if (nrm.is_zero) result_bits = {nrm.sgn, 63'd0};
      else result_bits = {nrm.sgn, 11'(nrm.exp + 13'sd1023), nrm.frac};
    end else begin
      if (nrm.is_nan) begin
        ex = emask; fr = 52'd1;
      end else if (nrm.is_inf) begin
        ex = emask;
      end else if (!nrm.is_zero) begin
        if (rawe >= $signed({2'b00, emask})) ex = emask;
        else if (rawe == 13'sd0) fr = sig[52:1] & fmask;
        else if (rawe > 13'sd0) begin
          ex = 11'(rawe); fr = sig[51:0] & fmask;
        end
      end
      result_bits = (64'(nrm.sgn) << (7'(ew) + 7'(mw)))
                  | (64'(ex & emask) << mw) | 64'(fr & fmask);
    end
  end
endmodule

// ===== sv/float_format_converter.sv =====
// ----------------------------------------------------------------------------
// float_format_converter
// Converts binary16/32/64 patterns to and from binary64.
// Stages: decode, normalize and pack, each followed by its own register.
// Throughput: one beat per cycle; the pipeline advances whenever the output
// register is empty or being drained.
// Reset: rst clears the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module float_format_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        ready_in,
  input  logic        req_type,
  input  logic [1:0]  fmt,
  input  logic [63:0] operand_bits,
  output logic        valid_out,
  input  logic        ready_out,
  output logic [63:0] result_bits
);
  import ffc_pkg::*;

  logic        v1, v2, v3;
  ffc_dec_t    d1, dec_next;
  ffc_norm_t   n2, norm_next;
  logic [63:0] r3, res_next;
  logic        adv;

  // Whole pipe moves when the last stage is free or its beat is taken.
  assign adv       = !v3 || ready_out;
  assign ready_in  = adv;
  assign valid_out = v3;
  assign result_bits = r3;

  ffc_decode u_dec (
    .narrow(req_type), .fmt(fmt_t'(fmt)), .operand_bits(operand_bits), .dec(dec_next)
  );
  ffc_norm u_norm (.dec(d1), .nrm(norm_next));
  ffc_pack u_pack (.nrm(n2), .result_bits(res_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (adv) begin
      v1 <= valid_in; v2 <= v1; v3 <= v2;
    end
  end

  // Payload: hold on stall, advance otherwise.
  always_ff @(posedge clk) begin
    if (adv) begin
      d1 <= dec_next;
      n2 <= norm_next;
      r3 <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid_out && !ready_out |=> valid_out && $stable(result_bits))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !valid_out |-> ready_in)
    else $error("pipe stalled while empty at output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    ready_in && v2 |=> valid_out)
    else $error("beat lost between stages");
`endif
endmodule
